/* sv/pwli_pkg.sv */
// Shared types and codes for the piecewise linear interpolator.
`default_nettype none
package pwli_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_y;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_APPEND,
        K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_cmd;

    typedef struct packed {
        logic vld;
        t_cmd cmd;
    } t_cmd_q;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH_LO,
        S_FETCH_HI,
        S_FETCH_WAIT,
        S_PREP,
        S_MUL,
        S_ADD,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

/* sv/piecewise_linear_interpolator.sv */
// Top level of the piecewise linear interpolator.
//
// Input queue: present an item on i_item with push; a transfer happens on a
// clock edge with push high and full low. Operation clear empties the table,
// append adds one (x, y) breakpoint (dropped when the table is full), query
// returns one result. Operation code 3 is taken and discarded.
// Result queue: while empty is low the oldest result sits on o_result; a
// transfer happens on an edge with pop high.
// A two-entry command queue parts the front end from the engine, and a
// one-entry result register parts the engine from the receiver, so items
// keep arriving while a result waits for pop.
// Clear and append are done by the engine in S_IDLE as it takes them. A query
// for a table of n points runs a search that reads one stored breakpoint a
// cycle from the table memory's single read port, then a 33x33 multiply and
// a radix-4 divider compute the result.
// Reset (i_rst_n low, synchronous) empties both queues and the table.
// When pop stays low the engine holds a finished query until the result
// register frees; items queue up to two deep and then full rises.
`default_nettype none
module piecewise_linear_interpolator
    import pwli_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_item,
    output logic          full,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_result
);

    t_cmd_q cmd;
    logic   take;

    pwli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_item  (i_item),
        .full    (full),
        .o_cmd   (cmd),
        .i_take  (take)
    );

    pwli_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_take   (take),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // no result left behind by reset
    a_reset_empty: assert property (@(posedge i_clk) $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status == ST_OK || o_result.status == ST_EMPTY ||
                    o_result.status == ST_DEGEN))
        else $error("bad status code");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == ST_EMPTY) |-> o_result.result_y == 32'sd0)
        else $error("empty-table result not zero");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

endmodule
`default_nettype wire

/* sv/pwli_front.sv */
// Front end: accepts items, drops unused operation codes, queues commands.
`default_nettype none
module pwli_front
    import pwli_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_item,
    output logic          full,
    output t_cmd_q        o_cmd,
    input  wire logic     i_take
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, keep;
    t_cmd       cls;

    always_comb begin
        cls.x    = i_item.point_x;
        cls.y    = i_item.point_y;
        keep     = 1'b1;
        cls.kind = K_QUERY;
        unique case (i_item.operation)
            OP_CLEAR:  cls.kind = K_CLEAR;
            OP_APPEND: cls.kind = K_APPEND;
            OP_QUERY:  cls.kind = K_QUERY;
            default:   keep     = 1'b0;
        endcase
    end

    assign full   = (r_cnt == 2'd2);
    assign accept = push && !full && keep;
    assign o_cmd.vld = (r_cnt != 2'd0);
    assign o_cmd.cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_take);
        end
    end

endmodule
`default_nettype wire

/* sv/pwli_back.sv */
// Back end: breakpoint table, segment search, multiply, divide, result register.
`default_nettype none
module pwli_back
    import pwli_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd_q  i_cmd,
    output logic         o_take,
    output logic         empty,
    input  wire logic    pop,
    output t_out_item    o_result
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    function automatic logic [34:0] div_step(logic [33:0] rem, logic b, logic [32:0] d);
        logic [33:0] sh;
        sh = {rem[32:0], b};
        if (sh >= {1'b0, d}) begin
            return {1'b1, sh - {1'b0, d}};
        end
        return {1'b0, sh};
    endfunction

    logic [31:0] mem_x [MAX_POINTS];
    logic [31:0] mem_y [MAX_POINTS];
    logic [31:0] r_rd_x, r_rd_y;

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic signed [31:0] r_qx, r_x0, r_y0, r_x1, r_y1;
    logic [IW-1:0] r_idx, r_cmp_idx, r_hi, rd_addr;
    logic r_cmp_vld, r_single, r_neg;
    logic [32:0] r_a, r_b, r_d;
    logic [63:0] r_p0;
    logic [65:0] r_dvd, r_quo;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic signed [31:0] r_res;
    logic [1:0] r_stat;
    logic r_out_vld;
    t_out_item r_out;

    logic hit, last, out_load, room, wr_en;
    logic signed [32:0] dx, dy, den;
    logic [65:0] prod;
    logic [34:0] s1, s2;
    logic [40:0] qc;
    logic signed [41:0] sum;
    logic signed [31:0] sat;

    assign room = (r_count < CW'(MAX_POINTS));
    assign hit  = (r_qx <= $signed(r_rd_x));
    assign last = (r_cmp_idx == IW'(r_count - CW'(1)));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.vld && i_cmd.cmd.kind == K_QUERY) begin
                    if (r_count == CW'(0)) begin
                        n_state = S_OUT;
                    end else if (r_count == CW'(1)) begin
                        n_state = S_FETCH_LO;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_cmp_vld && (hit || last)) begin
                    n_state = S_FETCH_LO;
                end
            end
            S_FETCH_LO:   n_state = S_FETCH_HI;
            S_FETCH_HI:   n_state = S_FETCH_WAIT;
            S_FETCH_WAIT: n_state = S_PREP;
            S_PREP: begin
                if (r_single || r_x1 == r_x0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 6'd1) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_take   = 1'b0;
        out_load = 1'b0;
        rd_addr  = r_idx;
        unique case (r_state)
            S_IDLE:     o_take   = i_cmd.vld;
            S_FETCH_LO: rd_addr  = r_hi - IW'(1);
            S_FETCH_HI: rd_addr  = r_hi;
            S_OUT:      out_load = !r_out_vld || pop;
            default:    rd_addr  = r_idx;
        endcase
    end

    assign wr_en = o_take && i_cmd.cmd.kind == K_APPEND && room;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[IW-1:0]] <= i_cmd.cmd.x;
            mem_y[r_count[IW-1:0]] <= i_cmd.cmd.y;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    // Datapath
    assign dx  = 33'(r_qx) - 33'(r_x0);
    assign dy  = 33'(r_y1) - 33'(r_y0);
    assign den = 33'(r_x1) - 33'(r_x0);

    assign prod = {2'b0, r_p0}
                + (r_a[32] ? {2'b0, r_b[31:0], 32'b0} : 66'd0)
                + (r_b[32] ? {2'b0, r_a[31:0], 32'b0} : 66'd0)
                + ((r_a[32] && r_b[32]) ? {2'b1, 64'd0} : 66'd0);

    assign s1 = div_step(r_rem, r_dvd[65], r_d);
    assign s2 = div_step(s1[33:0], r_dvd[64], r_d);

    // quotient clamps at 2^40
    assign qc  = ((|r_quo[65:41]) || (r_quo[40] && |r_quo[39:0])) ? {1'b1, 40'd0}
                                                                  : r_quo[40:0];
    assign sum = r_neg ? 42'(r_y0) - $signed({1'b0, qc}) : 42'(r_y0) + $signed({1'b0, qc});
    assign sat = (sum > 42'sd2147483647)  ? 32'sh7fffffff :
                 (sum < -42'sd2147483648) ? 32'sh80000000 : sum[31:0];

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qx      <= i_cmd.cmd.x;
                r_idx     <= IW'(1);
                r_hi      <= IW'(1);
                r_cmp_vld <= 1'b0;
                r_single  <= (r_count == CW'(1));
                r_res     <= '0;
                r_stat    <= ST_EMPTY;
            end
            S_SEARCH: begin
                r_idx     <= r_idx + IW'(1);
                r_cmp_idx <= r_idx;
                r_cmp_vld <= 1'b1;
                r_hi      <= r_cmp_idx;
            end
            S_FETCH_HI: begin
                r_x0 <= r_rd_x;
                r_y0 <= r_rd_y;
            end
            S_FETCH_WAIT: begin
                r_x1 <= r_rd_x;
                r_y1 <= r_rd_y;
            end
            S_PREP: begin
                r_a    <= dx[32]  ? -dx  : dx;
                r_b    <= dy[32]  ? -dy  : dy;
                r_d    <= den[32] ? -den : den;
                r_neg  <= dx[32] ^ dy[32] ^ den[32];
                r_res  <= r_y0;
                r_stat <= r_single ? ST_OK : ST_DEGEN;
            end
            S_MUL: r_p0 <= r_a[31:0] * r_b[31:0];
            S_ADD: begin
                r_dvd <= prod;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 6'd33;
            end
            S_DIV: begin
                r_rem <= s2[33:0];
                r_quo <= {r_quo[63:0], s1[34], s2[34]};
                r_dvd <= {r_dvd[63:0], 2'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            S_SUM: begin
                r_res  <= sat;
                r_stat <= ST_OK;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_take && i_cmd.cmd.kind == K_CLEAR) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.result_y <= r_res;
            r_out.status   <= r_stat;
        end
    end

    assign empty    = !r_out_vld;
    assign o_result = r_out;

endmodule
`default_nettype wire

/* dv/pwli_checker.sv */
// Checker for the piecewise linear interpolator: predicts query results and compares transfers.
`timescale 1ns / 1ps
module pwli_checker
    import pwli_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    input  wire logic      full,
    input  wire t_in_item  i_item,
    input  wire logic      empty,
    input  wire logic      pop,
    input  wire t_out_item o_result,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_queries_seen
);

    logic signed [31:0] table_x [MAX_POINTS];
    logic signed [31:0] table_y [MAX_POINTS];
    int                 table_len;
    t_out_item          expected_results [$];

    // y0 + trunc(dx*dy/den), saturated; quotient magnitude capped at 2^40 as the block does
    function automatic logic signed [31:0] seg_value(logic signed [31:0] y0,
                                                      logic signed [64:0] dx,
                                                      logic signed [64:0] dy,
                                                      logic signed [64:0] den);
        logic signed [130:0] prod;
        logic        [130:0] mag;
        logic        [130:0] dmag;
        logic        [130:0] quo;
        logic signed [63:0]  sum;
        logic                neg;
        prod = dx * dy;
        neg  = (prod < 0) != (den < 0);
        mag  = prod < 0 ? -prod : prod;
        dmag = den < 0 ? -den : den;
        quo  = mag / dmag;
        if (quo > (131'd1 << 40))
            quo = 131'd1 << 40;
        sum = neg ? 64'(y0) - 64'(quo) : 64'(y0) + 64'(quo);
        if (sum > 64'sd2147483647)
            return 32'sh7fffffff;
        if (sum < -64'sd2147483648)
            return 32'sh80000000;
        return sum[31:0];
    endfunction

    function automatic t_out_item answer_query(logic signed [31:0] q);
        t_out_item r;
        int lo_i;
        lo_i = -1;
        r.result_y = '0;
        r.status   = ST_OK;
        if (table_len == 0) begin
            r.status = ST_EMPTY;
        end else if (table_len == 1) begin
            r.result_y = table_y[0];
        end else begin
            for (int i = 1; i < table_len; i++) begin
                if (lo_i < 0 && q <= table_x[i])
                    lo_i = i - 1;
            end
            if (lo_i < 0)
                lo_i = table_len - 2;
            if (table_x[lo_i] == table_x[lo_i+1]) begin
                r.result_y = table_y[lo_i];
                r.status   = ST_DEGEN;
            end else begin
                r.result_y = seg_value(table_y[lo_i],
                                       65'(q) - 65'(table_x[lo_i]),
                                       65'(table_y[lo_i+1]) - 65'(table_y[lo_i]),
                                       65'(table_x[lo_i+1]) - 65'(table_x[lo_i]));
            end
        end
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            table_len = 0;
            expected_results.delete();
            o_fail_count   <= 0;
            o_queries_seen <= 0;
        end else begin
            if (push && !full) begin
                case (i_item.operation)
                    OP_CLEAR: table_len = 0;
                    OP_APPEND: begin
                        if (table_len < MAX_POINTS) begin
                            table_x[table_len] = i_item.point_x;
                            table_y[table_len] = i_item.point_y;
                            table_len++;
                        end
                    end
                    OP_QUERY: expected_results.insert(expected_results.size(),
                                                      answer_query(i_item.point_x));
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                o_queries_seen <= o_queries_seen + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transfer y=%0d st=%0d",
                                 o_result.result_y, o_result.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== o_result) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp y=%0d st=%0d, got y=%0d st=%0d",
                                     exp_r.result_y, exp_r.status,
                                     o_result.result_y, o_result.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* dv/tb_piecewise_linear_interpolator.sv */
// Testbench top for the piecewise linear interpolator: stimulus and verdict.
`timescale 1ns / 1ps
module tb_piecewise_linear_interpolator;
    import pwli_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    t_in_item  i_item;
    logic      full;
    logic      empty;
    logic      pop;
    t_out_item o_result;
    int        fail_count;
    int        pending;
    int        queries_seen;
    logic      stim_done;
    logic      hold_pop;
    int        items_sent;

    piecewise_linear_interpolator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    pwli_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_item         (i_item),
        .empty          (empty),
        .pop            (pop),
        .o_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_queries_seen (queries_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Coordinates: small grid mostly, full range sometimes
    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 32'($signed($urandom_range(0, 400)) - 200) <<< 12;
        if (r < 8)
            return $urandom;
        return r == 8 ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    // One transfer; item held until accepted, then push dropped only if a gap follows
    task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
        int g;
        i_item <= '{operation: op, point_x: x, point_y: y};
        push   <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        items_sent++;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Ascending table of n points with random spacing, occasionally a repeated x
    task automatic load_table(int n);
        logic signed [31:0] x;
        x = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 10;
        send_item(OP_CLEAR, $urandom, $urandom);
        for (int i = 0; i < n; i++) begin
            send_item(OP_APPEND, x, rand_coord());
            if ($urandom_range(0, 15) != 0)
                x = x + 32'($urandom_range(1, 1 << 20));
        end
    endtask

    // Receiver: random stalls; one long hold-off on request so the queues fill
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_pop) begin
                pop <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_pop = 1'b0;
            end else if ($urandom_range(0, 9) < 3) begin
                pop <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        #50_000_000;
        $display("** piecewise_linear_interpolator: FAILED **");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_item     = '0;
        stim_done  = 1'b0;
        hold_pop   = 1'b0;
        items_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, bad op, one point, degenerate pair, extremes, saturation
        send_item(OP_QUERY, 32'sh80000000, '0);
        send_item(2'd3, 32'sh7fffffff, 32'sh7fffffff);
        send_item(OP_APPEND, 32'sh00010000, 32'sh7fffffff);
        send_item(OP_QUERY, 32'sh7fffffff, '0);
        send_item(OP_APPEND, 32'sh00010000, 32'sh80000000);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_CLEAR, '1, '1);
        send_item(OP_APPEND, 32'sh80000000, 32'sh80000000);
        send_item(OP_APPEND, 32'sh80000001, 32'sh7fffffff);
        send_item(OP_QUERY, 32'sh7fffffff, '0);
        send_item(OP_QUERY, 32'sh80000000, '0);
        send_item(OP_APPEND, 32'sh7fffffff, 32'sh80000000);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_QUERY, 32'sh7ffffffe, 32'sh55555555);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_QUERY, 32'sh00001234, 32'shaaaaaaaa);

        // Fill past capacity, then query while the receiver holds off
        load_table(66);
        hold_pop = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(OP_QUERY, rand_coord(), $urandom);

        // Random: well-formed tables with query bursts, plus noise
        while (items_sent < 900) begin
            load_table($urandom_range(0, 9) == 0 ? $urandom_range(40, 64)
                                                 : $urandom_range(0, 8));
            repeat ($urandom_range(2, 10)) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
                else
                    send_item(OP_QUERY, rand_coord(), $urandom);
            end
        end
        push <= 1'b0;
        stim_done = 1'b1;

        waited = 0;
        while (pending != 0 && waited < 200_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        $display("Covered %0d items sent and %0d query results checked,", items_sent,
                 queries_seen);
        $display("with empty, single-point, degenerate, saturating and full-table cases.");
        if (fail_count == 0 && pending == 0) begin
            $display("** piecewise_linear_interpolator: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("** piecewise_linear_interpolator: FAILED **");
        end
        $finish;
    end

endmodule
